[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the rtl core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/asc_pkg.sv]
// ---------------------------------------------------------------------------
// asc_pkg
// shared types, codes and helpers for the alarm snooze controller
// ---------------------------------------------------------------------------
package asc_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int SNOOZE_W    = 6;
    localparam int WAKE_W      = 8;

    // item kind carried on tuser
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_KEY  = 1'b1;

    // key press codes
    localparam logic [1:0] KEY_SHORT = 2'd0;
    localparam logic [1:0] KEY_LONG  = 2'd1;
    localparam logic [1:0] KEY_VLONG = 2'd2;

    localparam logic [5:0] CHECK_SECOND = 6'd1;
    localparam logic [7:0] MINUTE_MAX   = 8'd59;
    localparam logic [7:0] MINUTES_HOUR = 8'd60;
    localparam logic [7:0] HOUR_MAX     = 8'd23;
    localparam logic [7:0] HOURS_DAY    = 8'd24;
    localparam logic [5:0] SNOOZE_RESET = 6'd5;

    typedef struct packed {
        logic       mode;
        logic [1:0] key_kind;
        logic [4:0] current_hour;
        logic [5:0] current_minute;
        logic [5:0] current_second;
        logic [3:0] minute_ones;
        logic [3:0] minute_tens;
        logic [3:0] hour_ones;
        logic [3:0] hour_tens;
    } asc_item_t;

    typedef struct packed {
        logic              alarm;
        logic              snooze;
        logic              wake;
        logic              seconds;
        logic [WAKE_W-1:0] wake_hour;
        logic [WAKE_W-1:0] wake_minute;
    } asc_state_t;

    // ones + 10 * tens, as shifts and an add, mod 256
    function automatic logic [7:0] digit_pair(input logic [3:0] ones, input logic [3:0] tens);
        logic [7:0] t8;
        t8 = {4'd0, tens};
        return (t8 << 3) + (t8 << 1) + {4'd0, ones};
    endfunction

endpackage

[rtl/core/alarm_snooze_controller.sv]
// ---------------------------------------------------------------------------
// alarm_snooze_controller
// alarm clock flag and wake time controller with snooze
// ---------------------------------------------------------------------------
//  channel   | dir | tdata fields (lsb first)                          | tuser
//  s_axis    | in  | key_kind, hour, minute, second, m1, m10, h1, h10   | mode
//  m_axis    | out | alarm, snooze, wake armed, secs shown, wake hh, mm | -
//  cfg       | in  | snooze length on cfg_wr_data when cfg_wr_en high  | -
//
//  one result transaction per input transaction, one item per cycle sustained while m_axis_tready stays high
//  the item passes through the input register and then the state register, which
//  is also the result register; the step logic feeds back from the state register
//  reset (aresetn low, synchronous) clears flags and wake time, snooze length 5
//  a stalled result holds the state and the input register; input is taken
//  while the input register is empty or drains in the same cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module alarm_snooze_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_axis_tdata: key_kind[1:0], current_hour[6:2], current_minute[12:7],
    // current_second[18:13], minute_ones[22:19], minute_tens[26:23],
    // hour_ones[30:27], hour_tens[34:31], zero pad[39:35]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [asc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tuser,   // mode
    // m_axis_tdata: alarm_on[0], snooze_on[1], wake_enabled[2], seconds_shown[3],
    // wake_hour_out[11:4], wake_minute_out[19:12], zero pad[23:20]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [asc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [asc_pkg::SNOOZE_W-1:0]        cfg_wr_data
);
    import asc_pkg::*;

    asc_item_t  in_item;
    asc_item_t  item;
    logic       item_valid;
    logic       advance;
    asc_state_t state_reg;
    asc_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [SNOOZE_W-1:0] snooze_reg;

    // unpack the incoming transaction
    always_comb begin
        in_item.mode           = s_axis_tuser;
        in_item.key_kind       = s_axis_tdata[1:0];
        in_item.current_hour   = s_axis_tdata[6:2];
        in_item.current_minute = s_axis_tdata[12:7];
        in_item.current_second = s_axis_tdata[18:13];
        in_item.minute_ones    = s_axis_tdata[22:19];
        in_item.minute_tens    = s_axis_tdata[26:23];
        in_item.hour_ones      = s_axis_tdata[30:27];
        in_item.hour_tens      = s_axis_tdata[34:31];
    end

    asc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // the registered item moves into the state once the previous result is gone or leaving
    assign advance = item_valid && (!m_valid_reg || m_axis_tready);

    asc_step u_step (
        .item       (item),
        .cur        (state_reg),
        .snooze_len (snooze_reg),
        .nxt        (state_next)
    );

    assign m_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
            snooze_reg  <= SNOOZE_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
            // the user must change configuration only while idle; the block does not enforce it
            if (cfg_wr_en) begin
                snooze_reg <= cfg_wr_data;
            end
        end
    end

    // the state registers double as the result register
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, state_reg.wake_minute, state_reg.wake_hour,
                            state_reg.seconds, state_reg.wake, state_reg.snooze,
                            state_reg.alarm};

    // snooze can only start from a ringing alarm
    `ASSERT_CLKD(a_snooze_from_alarm, aclk, aresetn,
        $rose(state_reg.snooze) |-> $past(state_reg.alarm), "snooze set without alarm")

    // state moves only with a step
    `ASSERT_CLKD(a_state_holds, aclk, aresetn,
        !advance |=> $stable(state_reg), "state changed without a step")

    // every step produces a result
    `ASSERT_CLKD(a_step_gives_result, aclk, aresetn,
        advance |=> m_valid_reg, "step without result")

    // a key outside alarm leaves the wake time alone
    `ASSERT_CLKD(a_key_keeps_wake, aclk, aresetn,
        advance && item.mode == MODE_KEY && !state_reg.alarm
        |=> $stable(state_reg.wake_hour) && $stable(state_reg.wake_minute),
        "wake time moved on key without alarm")

    // reset leaves no result pending
    `ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !m_valid_reg && !item_valid, "result pending after reset")

endmodule

[rtl/core/asc_in_stage.sv]
// ---------------------------------------------------------------------------
// asc_in_stage
// input register: captures one transaction, released when the step advances
// ---------------------------------------------------------------------------
module asc_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  asc_pkg::asc_item_t in_item,
    input  logic               advance,
    output logic               item_valid,
    output asc_pkg::asc_item_t item
);
    import asc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    asc_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/core/asc_step.sv]
// ---------------------------------------------------------------------------
// asc_step
// next flags and wake time for one key or tick item
// ---------------------------------------------------------------------------
module asc_step (
    input  asc_pkg::asc_item_t          item,
    input  asc_pkg::asc_state_t         cur,
    input  logic [asc_pkg::SNOOZE_W-1:0] snooze_len,
    output asc_pkg::asc_state_t         nxt
);
    import asc_pkg::*;

    logic [7:0] min_sum;
    logic [7:0] hour_inc;
    logic [7:0] snz_minute;
    logic [7:0] snz_hour;
    logic [7:0] load_minute;
    logic [7:0] load_hour;

    // snooze add with single minute and hour wrap
    always_comb begin
        min_sum  = cur.wake_minute + {2'd0, snooze_len};
        hour_inc = cur.wake_hour + 8'd1;
        if (min_sum > MINUTE_MAX) begin
            snz_minute = min_sum - MINUTES_HOUR;
            snz_hour   = (hour_inc > HOUR_MAX) ? hour_inc - HOURS_DAY : hour_inc;
        end else begin
            snz_minute = min_sum;
            snz_hour   = cur.wake_hour;
        end
    end

    always_comb begin
        load_minute = cur.snooze ? cur.wake_minute
                                 : digit_pair(item.minute_ones, item.minute_tens);
        load_hour   = cur.snooze ? cur.wake_hour
                                 : digit_pair(item.hour_ones, item.hour_tens);
    end

    always_comb begin
        nxt = cur;
        if (item.mode == MODE_KEY) begin
            if (cur.alarm || cur.snooze) begin
                case (item.key_kind)
                    KEY_SHORT: begin
                        nxt.snooze = 1'b1;
                        if (cur.alarm) begin
                            nxt.wake_minute = snz_minute;
                            nxt.wake_hour   = snz_hour;
                        end
                    end
                    KEY_LONG: begin
                        nxt.alarm  = 1'b0;
                        nxt.snooze = 1'b0;
                    end
                    default: ;
                endcase
            end else begin
                case (item.key_kind)
                    KEY_SHORT: nxt.wake    = !cur.wake;
                    KEY_LONG:  nxt.seconds = !cur.seconds;
                    default: ;
                endcase
            end
        end else if (item.current_second == CHECK_SECOND) begin
            nxt.wake_minute = load_minute;
            nxt.wake_hour   = load_hour;
            nxt.alarm       = cur.wake
                              && (load_minute == {2'd0, item.current_minute})
                              && (load_hour == {3'd0, item.current_hour});
        end
    end

endmodule
